// ===== hdl/rgb_to_hue_assert.svh =====
// ----------------------------------------------------------------------------
// rgb_to_hue_assert.svh
// Assertion helper macros used by the checker file rth_checker.sv.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HUE_ASSERT_SVH
`define RGB_TO_HUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rth_pkg.sv =====
// ----------------------------------------------------------------------------
// rth_pkg
// Shared widths, constants and types of the RGB to hue pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rth_pkg;

  // raw sensor channel
  localparam int unsigned ChanW = 16;
  localparam logic signed [ChanW:0] ScaleOffset = 17'sd5000;

  // scaling: trunc(n*256/7000) = trunc(n*32/875), done on |n|*32
  localparam int unsigned MagW       = 21;           // |n|*32 <= 1937120
  localparam logic [MagW-1:0] Recip  = 21'd1227134;  // ceil(2^30/875)
  localparam int unsigned RecipShift = 30;
  localparam int unsigned ProdW      = 2 * MagW;
  localparam int unsigned QuoW       = 12;           // scaled magnitude <= 2213
  localparam int unsigned ScW        = 13;           // scaled channel, signed

  // hue division
  localparam int unsigned SpanW = 12;                // max - min <= 2395
  localparam int unsigned NumW  = 18;                // |60*diff| <= 143700
  localparam int unsigned QBits = 6;                 // quotient <= 60
  localparam int unsigned HueW  = 9;
  localparam int unsigned HueSW = 10;                // signed hue before wrap
  localparam logic signed [HueSW-1:0] HueFull = 10'sd360;

  typedef logic signed [ScW-1:0] scaled_t;

  typedef enum logic [1:0] {
    SecRed   = 2'd0,
    SecGreen = 2'd1,
    SecBlue  = 2'd2
  } sector_e;

  // word handed from sector select to the divider
  typedef struct packed {
    logic [NumW-1:0]  num_mag;
    logic             neg;
    logic [SpanW-1:0] span;
    sector_e          sector;
    logic             zero;
  } sec_t;

  // sector base angle
  function automatic logic signed [HueSW-1:0] sector_offset(sector_e sec);
    logic signed [HueSW-1:0] off;
    case (sec)
      SecRed:   off = 10'sd0;
      SecGreen: off = 10'sd120;
      SecBlue:  off = 10'sd240;
      default:  off = 10'sd0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rth_scale.sv =====
// ----------------------------------------------------------------------------
// rth_scale
// Three-stage offset and rescale of one raw channel: trunc((x-5000)*256/7000).
// ----------------------------------------------------------------------------
`default_nettype none

module rth_scale (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic [rth_pkg::ChanW-1:0] raw_i,
  output rth_pkg::scaled_t             scaled_o
);
  import rth_pkg::*;

  logic signed [ChanW:0] diff_s;
  logic [ChanW:0]        abs_v;
  logic [MagW-1:0]       mag_d, mag_q;
  logic                  neg1_q, neg2_q;
  logic [ProdW-1:0]      prod_d, prod_q;
  logic [QuoW-1:0]       quo;
  scaled_t               scaled_d, scaled_q;

  // stage 1: remove offset, take magnitude, times 32
  assign diff_s = $signed({1'b0, raw_i}) - ScaleOffset;
  assign abs_v  = diff_s[ChanW] ? (ChanW+1)'(-diff_s) : (ChanW+1)'(diff_s);
  assign mag_d  = {abs_v[ChanW-1:0], 5'b0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      neg1_q <= diff_s[ChanW];
    end
  end

  // stage 2: reciprocal multiply for the divide by 875
  assign prod_d = ProdW'(mag_q) * ProdW'(Recip);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      neg2_q <= neg1_q;
    end
  end

  // stage 3: quotient, sign restored (truncation toward zero)
  assign quo      = prod_q[RecipShift +: QuoW];
  assign scaled_d = neg2_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      scaled_q <= scaled_d;
    end
  end

  assign scaled_o = scaled_q;

endmodule

`default_nettype wire

// ===== hdl/rth_sector.sv =====
// ----------------------------------------------------------------------------
// rth_sector
// Max/min of the scaled channels, sector choice, span and 60*diff numerator.
// ----------------------------------------------------------------------------
`default_nettype none

module rth_sector (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  rth_pkg::scaled_t  red_i,
  input  rth_pkg::scaled_t  green_i,
  input  rth_pkg::scaled_t  blue_i,
  output rth_pkg::sec_t     sec_o
);
  import rth_pkg::*;

  localparam int unsigned DW = ScW + 1;
  localparam int unsigned MW = DW + 6;

  logic                 red_max, green_max;
  scaled_t              hi, lo;
  logic signed [DW-1:0] span_s, diff_s;
  logic signed [MW-1:0] num_s;
  logic [MW-1:0]        num_abs;
  sec_t                 sec_d, sec_q;

  // largest channel; ties go red, then green
  assign red_max   = (red_i >= green_i) && (red_i >= blue_i);
  assign green_max = !red_max && (green_i >= blue_i);

  always_comb begin
    hi = red_i;
    lo = red_i;
    if (green_i > hi) hi = green_i;
    if (blue_i > hi)  hi = blue_i;
    if (green_i < lo) lo = green_i;
    if (blue_i < lo)  lo = blue_i;
  end

  assign span_s = DW'(hi) - DW'(lo);

  // sector difference
  always_comb begin
    if (red_max) begin
      diff_s = DW'(green_i) - DW'(blue_i);
    end else if (green_max) begin
      diff_s = DW'(blue_i) - DW'(red_i);
    end else begin
      diff_s = DW'(red_i) - DW'(green_i);
    end
  end

  // 60*diff = 64*diff - 4*diff
  assign num_s   = (MW'(diff_s) <<< 6) - (MW'(diff_s) <<< 2);
  assign num_abs = num_s[MW-1] ? MW'(-num_s) : MW'(num_s);

  always_comb begin
    sec_d.num_mag = num_abs[NumW-1:0];
    sec_d.neg     = num_s[MW-1];
    sec_d.span    = span_s[SpanW-1:0];
    sec_d.sector  = red_max ? SecRed : (green_max ? SecGreen : SecBlue);
    sec_d.zero    = (hi == lo);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sec_q <= sec_d;
    end
  end

  assign sec_o = sec_q;

endmodule

`default_nettype wire

// ===== hdl/rth_div.sv =====
// ----------------------------------------------------------------------------
// rth_div
// Pipelined restoring divide of |60*diff| by span, two quotient bits per
// stage, then floor correction, sector offset and wrap into 0..359.
// ----------------------------------------------------------------------------
`default_nettype none

module rth_div (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  rth_pkg::sec_t                 sec_i,
  output logic [rth_pkg::HueW-1:0]      hue_o
);
  import rth_pkg::*;

  localparam int unsigned NStg = QBits / 2;

  typedef struct packed {
    logic [NumW-1:0]  rem;
    logic [SpanW-1:0] span;
    logic [QBits-1:0] quo;
    logic             neg;
    sector_e          sector;
    logic             zero;
  } dv_t;

  // one restoring step on quotient bit idx
  function automatic dv_t div_step(dv_t st, int unsigned idx);
    dv_t             nx;
    logic [NumW-1:0] dvs;
    nx  = st;
    dvs = NumW'(st.span) << idx;
    if (st.rem >= dvs) begin
      nx.rem      = st.rem - dvs;
      nx.quo[idx] = 1'b1;
    end
    return nx;
  endfunction

  dv_t dv_in [NStg];
  dv_t dv_q  [NStg];

  // entry word
  always_comb begin
    dv_in[0].rem    = sec_i.num_mag;
    dv_in[0].span   = sec_i.span;
    dv_in[0].quo    = '0;
    dv_in[0].neg    = sec_i.neg;
    dv_in[0].sector = sec_i.sector;
    dv_in[0].zero   = sec_i.zero;
  end

  // divider stages, MSB pair first
  for (genvar k = 0; k < NStg; k++) begin : g_stg
    if (k > 0) begin : g_link
      assign dv_in[k] = dv_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[k] <= div_step(div_step(dv_in[k], QBits - 1 - 2*k), QBits - 2 - 2*k);
      end
    end
  end

  // floor correction, offset and wrap
  dv_t                     dv_last;
  logic signed [7:0]       q_s;
  logic signed [HueSW-1:0] hue_s, hue_w;
  logic [HueW-1:0]         hue_d, hue_q;

  assign dv_last = dv_q[NStg-1];

  always_comb begin
    if (dv_last.neg) begin
      q_s = -$signed({2'b0, dv_last.quo}) - ((dv_last.rem != '0) ? 8'sd1 : 8'sd0);
    end else begin
      q_s = $signed({2'b0, dv_last.quo});
    end
    hue_s = sector_offset(dv_last.sector) + HueSW'(q_s);
    hue_w = hue_s[HueSW-1] ? hue_s + HueFull : hue_s;
    hue_d = dv_last.zero ? '0 : hue_w[HueW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_q <= hue_d;
    end
  end

  assign hue_o = hue_q;

endmodule

`default_nettype wire

// ===== hdl/rgb_to_hue.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hue
// Hue in whole degrees from one raw red, green and blue sensor sample.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_* takes one word per sample: red, green and blue,
//   16 bits each. Master channel m_axis_* returns one word per sample with
//   the hue, 0..359, in its low 9 bits.
//   The datapath is an 8-register pipeline: three stages of channel scaling
//   (offset, reciprocal multiply, sign), one sector/span stage, three
//   divider stages of two quotient bits each and the output register.
//   Throughput is one word per cycle while the receiver keeps tready high.
//   When the output word is held by a low m_axis_tready, the whole pipe
//   freezes and s_axis_tready drops; nothing is dropped or repeated.
//   Reset clears all valid bits; the block is ready right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // [15:0] red, [31:16] green, [47:32] blue
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [8:0] hue, [15:9] zero
);
  import rth_pkg::*;

  localparam int unsigned Lat = 8;

  logic           adv;
  logic [Lat-1:0] vld_q, vld_d;
  scaled_t        red_s, green_s, blue_s;
  sec_t           sec;
  logic [HueW-1:0] hue;

  // pipe advances unless the output word is stalled
  assign adv           = !vld_q[Lat-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign vld_d         = {vld_q[Lat-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // channel scaling
  rth_scale u_scale_r (
    .clk_i    (clk_i),
    .en_i     (adv),
    .raw_i    (s_axis_tdata[15:0]),
    .scaled_o (red_s)
  );

  rth_scale u_scale_g (
    .clk_i    (clk_i),
    .en_i     (adv),
    .raw_i    (s_axis_tdata[31:16]),
    .scaled_o (green_s)
  );

  rth_scale u_scale_b (
    .clk_i    (clk_i),
    .en_i     (adv),
    .raw_i    (s_axis_tdata[47:32]),
    .scaled_o (blue_s)
  );

  // sector, span and numerator
  rth_sector u_sector (
    .clk_i   (clk_i),
    .en_i    (adv),
    .red_i   (red_s),
    .green_i (green_s),
    .blue_i  (blue_s),
    .sec_o   (sec)
  );

  // divide and final hue
  rth_div u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .sec_i (sec),
    .hue_o (hue)
  );

  assign m_axis_tvalid = vld_q[Lat-1];
  assign m_axis_tdata  = {7'b0, hue};

endmodule

`default_nettype wire

// ===== hdl/rth_checker.sv =====
// ----------------------------------------------------------------------------
// rth_checker
// Port-level checks of the RGB to hue block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_to_hue_assert.svh"

module rth_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // hue is always a valid angle
  `RTH_ASSERT_NOW(a_hue_range, m_axis_tvalid, m_axis_tdata[8:0] < 9'd360, "hue out of range")

  // pad bits of the output word stay zero
  `RTH_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[15:9] == 7'd0, "output pad not zero")

  // stalled output word holds
  `RTH_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata), "stalled output changed")

  // input side only blocks while an output word is stalled
  `RTH_ASSERT_NOW(a_in_ready, !m_axis_tvalid || m_axis_tready, s_axis_tready,
                  "input not ready with free output")

endmodule

bind rgb_to_hue rth_checker u_rth_checker (.*);

`default_nettype wire
